// ===== design/tks_pkg.sv =====
`default_nettype none

package tks_pkg;

  // Step address of the control program
  typedef logic [3:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_OFF_CHK = 4'd1;
  localparam step_t S_OFF_CMP = 4'd2;
  localparam step_t S_INS_RD  = 4'd3;
  localparam step_t S_INS_CMP = 4'd4;
  localparam step_t S_INS_NEW = 4'd5;
  localparam step_t S_DR_CHK  = 4'd6;
  localparam step_t S_DR_RD   = 4'd7;
  localparam step_t S_DR_EMIT = 4'd8;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_OFF_CHK,
    OP_OFF_CMP,
    OP_INS_RD,
    OP_INS_CMP,
    OP_INS_NEW,
    OP_DR_CHK,
    OP_DR_RD,
    OP_DR_EMIT
  } op_t;

  // Branch condition of one step
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_MODE,
    COND_NOT_FULL,
    COND_NEW_BELOW,
    COND_POS_ZERO,
    COND_RD_BELOW,
    COND_EMPTY,
    COND_DR_LAST
  } cond_t;

  // Mode codes of a request
  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctrl_t;

  // Control ROM: one word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    unique case (s)
      S_IDLE:    w = '{OP_WAIT,    COND_MODE,      S_DR_CHK,  S_OFF_CHK};
      S_OFF_CHK: w = '{OP_OFF_CHK, COND_NOT_FULL,  S_INS_RD,  S_OFF_CMP};
      S_OFF_CMP: w = '{OP_OFF_CMP, COND_NEW_BELOW, S_IDLE,    S_INS_RD};
      S_INS_RD:  w = '{OP_INS_RD,  COND_POS_ZERO,  S_INS_NEW, S_INS_CMP};
      S_INS_CMP: w = '{OP_INS_CMP, COND_RD_BELOW,  S_INS_RD,  S_INS_NEW};
      S_INS_NEW: w = '{OP_INS_NEW, COND_ALWAYS,    S_IDLE,    S_IDLE};
      S_DR_CHK:  w = '{OP_DR_CHK,  COND_EMPTY,     S_IDLE,    S_DR_RD};
      S_DR_RD:   w = '{OP_DR_RD,   COND_NEVER,     S_DR_EMIT, S_DR_EMIT};
      S_DR_EMIT: w = '{OP_DR_EMIT, COND_DR_LAST,   S_IDLE,    S_DR_RD};
      default:   w = '{OP_WAIT,    COND_ALWAYS,    S_IDLE,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/tks_in_if.sv =====
`default_nettype none

interface tks_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] item_id;
  logic [31:0] score;

  modport source (output valid, mode, item_id, score, input ready);
  modport sink   (input valid, mode, item_id, score, output ready);
endinterface

`default_nettype wire

// ===== design/tks_out_if.sv =====
`default_nettype none

interface tks_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [31:0] out_score;
  logic        accepted;
  logic        empty_res;
  logic        last;

  modport source (output valid, out_id, out_score, accepted, empty_res, last,
                  input ready);
  modport sink   (input valid, out_id, out_score, accepted, empty_res, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/top_k_score_selector_top.sv =====
`default_nettype none

// Channel  Modport  Payload
// item     sink     mode, item_id[15:0], score[31:0] (Q16.16)
// result   source   out_id[15:0], out_score[31:0], accepted, empty_res, last
//
// Each request is accepted at the idle step. The steps after it:
// Offer: check the held count; when the set is full, compare with the minimum
// and reject the offer or drop the last slot; then walk the entry RAM
// (registered read, then compare), shifting each lower entry down, and write
// the new entry. Drain: check for empty, then read and emit each held entry.
// rst is synchronous and clears the step counter, held count and result valid.
// A result waits in the output register; the sequencer holds on an emitting
// step only while that register is full and not being taken.

module top_k_score_selector_top #(
  parameter int KEEP_COUNT = 10,
  parameter int ID_BITS    = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  tks_in_if.sink    item,
  tks_out_if.source result
);

  localparam int AW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int CW = $clog2(KEEP_COUNT + 1);
  localparam int EW = ID_BITS + 32;

  tks_pkg::step_t   step;
  tks_pkg::ctrl_t   ctrl;
  logic [CW-1:0]    count;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    idx;
  logic [ID_BITS-1:0] new_id;
  logic [31:0]      new_score;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    rd_data;
  logic [ID_BITS-1:0] rd_id;
  logic [31:0]      rd_score;

  logic             in_fire;
  logic             out_free;
  logic             full;
  logic             new_below;
  logic             rd_below;
  logic             dr_last;
  logic             emit_req;
  logic             hold;
  logic             go;
  logic             cond_hit;

  logic [ID_BITS+15:0] in_id_ext;
  logic [ID_BITS+15:0] rd_id_ext;

  assign ctrl = tks_pkg::ucode(step);

  assign rd_id    = rd_data[EW-1:32];
  assign rd_score = rd_data[31:0];

  // Fit the port id to ID_BITS and back to 16 bits
  assign in_id_ext = {{ID_BITS{1'b0}}, item.item_id};
  assign rd_id_ext = {16'h0000, rd_id};

  assign item.ready = (step == tks_pkg::S_IDLE);
  assign in_fire    = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;

  assign full      = (count == CW'(KEEP_COUNT));
  assign new_below = (new_score < rd_score);
  assign rd_below  = (rd_score < new_score);
  assign dr_last   = ((CW'(idx) + CW'(1)) == count);

  // Steps that load the output register
  always_comb begin
    unique case (ctrl.op)
      tks_pkg::OP_OFF_CMP: emit_req = new_below;
      tks_pkg::OP_INS_NEW: emit_req = 1'b1;
      tks_pkg::OP_DR_CHK:  emit_req = (count == '0);
      tks_pkg::OP_DR_EMIT: emit_req = 1'b1;
      default:             emit_req = 1'b0;
    endcase
  end

  assign hold = ((ctrl.op == tks_pkg::OP_WAIT) && !in_fire) || (emit_req && !out_free);
  assign go   = !hold;

  // Branch condition
  always_comb begin
    unique case (ctrl.cond)
      tks_pkg::COND_NEVER:     cond_hit = 1'b0;
      tks_pkg::COND_ALWAYS:    cond_hit = 1'b1;
      tks_pkg::COND_MODE:      cond_hit = (item.mode == tks_pkg::MODE_DRAIN);
      tks_pkg::COND_NOT_FULL:  cond_hit = !full;
      tks_pkg::COND_NEW_BELOW: cond_hit = new_below;
      tks_pkg::COND_POS_ZERO:  cond_hit = (pos == '0);
      tks_pkg::COND_RD_BELOW:  cond_hit = rd_below;
      tks_pkg::COND_EMPTY:     cond_hit = (count == '0);
      tks_pkg::COND_DR_LAST:   cond_hit = dr_last;
      default:                 cond_hit = 1'b0;
    endcase
  end

  // Entry RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = {new_id, new_score};
    ram_re    = 1'b0;
    ram_raddr = idx;
    unique case (ctrl.op)
      tks_pkg::OP_OFF_CHK: begin
        ram_re    = go && full;
        ram_raddr = AW'(KEEP_COUNT - 1);
      end
      tks_pkg::OP_INS_RD: begin
        ram_re    = go && (pos != '0);
        ram_raddr = pos - AW'(1);
      end
      tks_pkg::OP_INS_CMP: begin
        ram_we    = go && rd_below;
        ram_wdata = rd_data;
      end
      tks_pkg::OP_INS_NEW: begin
        ram_we    = go;
      end
      tks_pkg::OP_DR_RD: begin
        ram_re    = go;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  tks_ram #(
    .WIDTH (EW),
    .DEPTH (KEEP_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= tks_pkg::S_IDLE;
      count <= '0;
    end else if (go) begin
      step <= cond_hit ? ctrl.t_true : ctrl.t_false;
      unique case (ctrl.op)
        tks_pkg::OP_WAIT: begin
          new_id    <= in_id_ext[ID_BITS-1:0];
          new_score <= item.score;
        end
        tks_pkg::OP_OFF_CHK: begin
          if (!full) begin
            pos <= AW'(count);
          end
        end
        tks_pkg::OP_OFF_CMP: begin
          // replace the minimum: drop the last slot and insert from there
          if (!new_below) begin
            pos   <= AW'(KEEP_COUNT - 1);
            count <= count - CW'(1);
          end
        end
        tks_pkg::OP_INS_CMP: begin
          if (rd_below) begin
            pos <= pos - AW'(1);
          end
        end
        tks_pkg::OP_INS_NEW: begin
          count <= count + CW'(1);
        end
        tks_pkg::OP_DR_CHK: begin
          idx <= '0;
        end
        tks_pkg::OP_DR_EMIT: begin
          if (dr_last) begin
            count <= '0;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (go && emit_req) begin
        result.valid     <= 1'b1;
        result.out_id    <= '0;
        result.out_score <= '0;
        result.accepted  <= 1'b0;
        result.empty_res <= 1'b0;
        result.last      <= 1'b1;
        unique case (ctrl.op)
          tks_pkg::OP_INS_NEW: begin
            result.accepted <= 1'b1;
          end
          tks_pkg::OP_DR_CHK: begin
            result.empty_res <= 1'b1;
          end
          tks_pkg::OP_DR_EMIT: begin
            result.out_id    <= rd_id_ext[15:0];
            result.out_score <= rd_score;
            result.last      <= dr_last;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Held count never exceeds the set size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(KEEP_COUNT))
    else $error("held count above set size");

  // A finished drain leaves the set empty
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (step == tks_pkg::S_DR_EMIT && go && dr_last) |=> (count == '0))
    else $error("drain did not clear the set");

  // Insertion slot stays within the held entries
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    (step == tks_pkg::S_INS_RD || step == tks_pkg::S_INS_CMP) |-> (CW'(pos) <= count))
    else $error("insertion slot beyond held count");

  // Requests are taken only at the idle step
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (step == tks_pkg::S_DR_CHK || step == tks_pkg::S_OFF_CHK))
    else $error("request not dispatched");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (go && emit_req) |-> out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== design/tks_ram.sv =====
`default_nettype none

module tks_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
